// ----- rtl/keyed_mailbox_queue_core_assert.svh -----
// Assertion macros for the keyed mailbox queue core.
// Included by modules that check their own control logic.
`ifndef KEYED_MAILBOX_QUEUE_CORE_ASSERT_SVH
`define KEYED_MAILBOX_QUEUE_CORE_ASSERT_SVH

// Assert an implication on every rising clock edge outside reset.
`define KMQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert a next-cycle implication outside reset.
`define KMQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/kmq_pkg.sv -----
// Shared types and codes for the keyed mailbox queue core.
// No dependencies.
package kmq_pkg;

    localparam int ID_W   = 8;
    localparam int WORD_W = 32;

    typedef enum logic [0:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef struct packed {
        logic               operation;
        logic [ID_W-1:0]    receiver_id;
        logic [ID_W-1:0]    sender_id;
        logic signed [WORD_W-1:0] payload;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [ID_W-1:0]    out_receiver_id;
        logic [ID_W-1:0]    out_sender_id;
        logic signed [WORD_W-1:0] out_payload;
    } t_rsp;

endpackage

// ----- rtl/keyed_mailbox_queue_core.sv -----
// Keyed mailbox queue: sorted message store in one synchronous memory.
// Depends on kmq_pkg and keyed_mailbox_queue_core_assert.svh.
//
//  channel   | handshake           | payload
//  request   | i_start / o_busy    | i_req  (kmq_pkg::t_req)
//  result    | o_done (one cycle)  | o_rsp  (kmq_pkg::t_rsp)
//
// o_busy rises the cycle after a request is taken; o_done rises in the same
// cycle as o_busy falls. Scan and shift walk the memory one entry a cycle,
// with no stall; a full-store drop skips the walk.
// Reset clears the count and control; memory holds no reset. No stall on o_done.
module keyed_mailbox_queue_core #(
    parameter int MAILBOX_DEPTH = 16,
    parameter int ID_BITS       = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  kmq_pkg::t_req  i_req,
    output logic           o_busy,
    output logic           o_done,
    output kmq_pkg::t_rsp  o_rsp
);

`include "keyed_mailbox_queue_core_assert.svh"

    localparam int AW = (MAILBOX_DEPTH > 1) ? $clog2(MAILBOX_DEPTH) : 1;
    localparam int CW = $clog2(MAILBOX_DEPTH + 1);
    localparam int EW = 2 * kmq_pkg::ID_W + kmq_pkg::WORD_W;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_SHUP  = 6'b000100,
        S_SHDN  = 6'b001000,
        S_FIN   = 6'b010000,
        S_RESP  = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;      // address being read
    logic              r_rdv, n_rdv;      // read data valid this cycle
    kmq_pkg::t_req     r_req, n_req;
    kmq_pkg::t_rsp     r_rsp, n_rsp;
    logic              r_done, n_done;
    logic [CW-1:0]     r_pos, n_pos;

    // Memory and port
    logic [EW-1:0]     mem [MAILBOX_DEPTH];
    logic [EW-1:0]     r_rdata;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [EW-1:0]     mem_wdata;

    logic [kmq_pkg::ID_W-1:0] id_mask, key, ent_rcv;
    assign id_mask = kmq_pkg::ID_W'((1 << ID_BITS) - 1);
    assign key     = r_req.receiver_id & id_mask;
    assign ent_rcv = r_rdata[EW-1 -: kmq_pkg::ID_W];

    // Hold the store; reads are registered
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    // Sequence scan, shift and response
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_idx     = r_idx;
        n_rdv     = 1'b0;
        n_req     = r_req;
        n_rsp     = r_rsp;
        n_done    = 1'b0;
        n_pos     = r_pos;
        mem_we    = 1'b0;
        mem_waddr = r_idx[AW-1:0];
        mem_raddr = r_idx[AW-1:0];
        mem_wdata = r_rdata;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_req   = i_req;
                    n_req.receiver_id = i_req.receiver_id & id_mask;
                    n_req.sender_id   = i_req.sender_id & id_mask;
                    n_rsp   = '0;
                    n_idx   = '0;
                    if (i_req.operation == kmq_pkg::OP_ENQ &&
                        r_count == CW'(MAILBOX_DEPTH)) begin
                        n_rsp.status = kmq_pkg::ST_FULL;
                        n_state = S_RESP;
                    end else if (r_count == '0) begin
                        n_pos   = '0;
                        if (i_req.operation == kmq_pkg::OP_ENQ) begin
                            n_state = S_FIN;
                        end else begin
                            n_rsp.status = kmq_pkg::ST_NOTFOUND;
                            n_state = S_RESP;
                        end
                    end else begin
                        mem_raddr = '0;
                        n_rdv   = 1'b1;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // compare entry r_idx, prefetch next
                if (r_req.operation == kmq_pkg::OP_ENQ) begin
                    if (ent_rcv > key) begin
                        n_pos = r_idx;
                        // open gap from top: read count-1
                        n_idx = r_count - 1'b1;
                        mem_raddr = n_idx[AW-1:0];
                        n_state = S_SHUP;
                    end else if (r_idx + 1'b1 == r_count) begin
                        n_pos   = r_count;
                        n_state = S_FIN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        mem_raddr = n_idx[AW-1:0];
                    end
                end else begin
                    if (ent_rcv == key) begin
                        n_rsp.status          = kmq_pkg::ST_OK;
                        n_rsp.out_receiver_id = ent_rcv;
                        n_rsp.out_sender_id   = r_rdata[EW-kmq_pkg::ID_W-1 -: kmq_pkg::ID_W];
                        n_rsp.out_payload     = r_rdata[kmq_pkg::WORD_W-1:0];
                        n_count = r_count - 1'b1;
                        if (r_idx + 1'b1 == r_count) begin
                            n_state = S_RESP;
                        end else begin
                            n_idx = r_idx + 1'b1;
                            mem_raddr = n_idx[AW-1:0];
                            n_state = S_SHDN;
                        end
                    end else if (r_idx + 1'b1 == r_count) begin
                        n_rsp.status = kmq_pkg::ST_NOTFOUND;
                        n_state = S_RESP;
                    end else begin
                        n_idx = r_idx + 1'b1;
                        mem_raddr = n_idx[AW-1:0];
                    end
                end
            end
            S_SHUP: begin
                // move entry r_idx to r_idx+1, then step down
                mem_we    = 1'b1;
                mem_waddr = AW'(r_idx + 1'b1);
                if (r_idx == r_pos) begin
                    n_state = S_FIN;
                end else begin
                    n_idx = r_idx - 1'b1;
                    mem_raddr = n_idx[AW-1:0];
                end
            end
            S_SHDN: begin
                // move entry r_idx to r_idx-1, then step up
                mem_we    = 1'b1;
                mem_waddr = AW'(r_idx - 1'b1);
                if (r_idx == r_count) begin
                    n_state = S_RESP;
                end else begin
                    n_idx = r_idx + 1'b1;
                    mem_raddr = n_idx[AW-1:0];
                end
            end
            S_FIN: begin
                // write the new message into the gap
                mem_we    = 1'b1;
                mem_waddr = r_pos[AW-1:0];
                mem_wdata = {r_req.receiver_id, r_req.sender_id, r_req.payload};
                n_count   = r_count + 1'b1;
                n_state   = S_RESP;
            end
            S_RESP: begin
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_done  <= 1'b0;
            r_rdv   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_done  <= n_done;
            r_rdv   <= n_rdv;
        end
    end

    // Hold request payload and working indexes
    always_ff @(posedge i_clk) begin
        r_req <= n_req;
        r_rsp <= n_rsp;
        r_idx <= n_idx;
        r_pos <= n_pos;
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    `KMQ_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAILBOX_DEPTH))
    `KMQ_ASSERT_NEXT(a_done_after_resp, i_clk, i_rst_n, r_state == S_RESP, o_done && !o_busy)
    `KMQ_ASSERT_NEXT(a_scan_read, i_clk, i_rst_n, r_state == S_IDLE && i_start && n_state == S_SCAN, r_rdv)
    `KMQ_ASSERT_IMP(a_full_no_write, i_clk, i_rst_n, r_state == S_FIN, r_count < CW'(MAILBOX_DEPTH))

endmodule

// ----- tb/keyed_mailbox_queue_core_tb.sv -----
// Testbench for keyed_mailbox_queue_core: directed and random requests,
// every result checked against a sorted-store predictor. Depends on kmq_pkg.
module keyed_mailbox_queue_core_tb;

    localparam int DEPTH = 16;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_start = 1'b0;
    kmq_pkg::t_req  i_req = '0;
    logic           o_busy;
    logic           o_done;
    kmq_pkg::t_rsp  o_rsp;

    keyed_mailbox_queue_core #(.MAILBOX_DEPTH(DEPTH), .ID_BITS(8)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_req(i_req),
        .o_busy(o_busy), .o_done(o_done), .o_rsp(o_rsp)
    );

    always #6 i_clk = ~i_clk;

    // Predictor state: sorted mailbox copy
    logic [7:0]     mb_rcv [DEPTH];
    logic [7:0]     mb_snd [DEPTH];
    logic [31:0]    mb_word [DEPTH];
    int             mb_count = 0;
    kmq_pkg::t_rsp  rsp_queue [$];
    int             err_count = 0;
    int             burst_left = 0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH: %s at %0t", what, $realtime);
        err_count++;
    endtask

    // Compute the result of one request and advance the mailbox copy
    function automatic kmq_pkg::t_rsp predict_mailbox(input kmq_pkg::t_req rq);
        kmq_pkg::t_rsp r;
        int   pos;
        r = '0;
        if (rq.operation == kmq_pkg::OP_ENQ) begin
            if (mb_count >= DEPTH) begin
                r.status = kmq_pkg::ST_FULL;
            end else begin
                pos = 0;
                while (pos < mb_count && mb_rcv[pos] <= rq.receiver_id) pos++;
                for (int i = mb_count; i > pos; i--) begin
                    mb_rcv[i] = mb_rcv[i-1];
                    mb_snd[i] = mb_snd[i-1];
                    mb_word[i] = mb_word[i-1];
                end
                mb_rcv[pos] = rq.receiver_id;
                mb_snd[pos] = rq.sender_id;
                mb_word[pos] = rq.payload;
                mb_count++;
                r.status = kmq_pkg::ST_OK;
            end
        end else begin
            pos = 0;
            while (pos < mb_count && mb_rcv[pos] != rq.receiver_id) pos++;
            if (pos >= mb_count) begin
                r.status = kmq_pkg::ST_NOTFOUND;
            end else begin
                r.status = kmq_pkg::ST_OK;
                r.out_receiver_id = mb_rcv[pos];
                r.out_sender_id = mb_snd[pos];
                r.out_payload = mb_word[pos];
                for (int i = pos; i + 1 < mb_count; i++) begin
                    mb_rcv[i] = mb_rcv[i+1];
                    mb_snd[i] = mb_snd[i+1];
                    mb_word[i] = mb_word[i+1];
                end
                mb_count--;
            end
        end
        return r;
    endfunction

    // Send one request; idle in bursts with random gaps
    task automatic send_request(input kmq_pkg::t_op op, input logic [7:0] rcv,
                                input logic [7:0] snd, input logic [31:0] word);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_req <= '{operation: op, receiver_id: rcv, sender_id: snd, payload: word};
        do @(posedge i_clk); while (o_busy);
        rsp_queue.push_back(predict_mailbox(i_req));
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        kmq_pkg::t_rsp want;
        if (i_rst_n && o_done) begin
            if (rsp_queue.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                want = rsp_queue.pop_front();
                if (o_rsp.status !== want.status)
                    report_mismatch($sformatf("status %0d want %0d", o_rsp.status, want.status));
                if (o_rsp.out_receiver_id !== want.out_receiver_id)
                    report_mismatch($sformatf("receiver %0h want %0h",
                        o_rsp.out_receiver_id, want.out_receiver_id));
                if (o_rsp.out_sender_id !== want.out_sender_id)
                    report_mismatch($sformatf("sender %0h want %0h",
                        o_rsp.out_sender_id, want.out_sender_id));
                if (o_rsp.out_payload !== want.out_payload)
                    report_mismatch($sformatf("payload %0h want %0h",
                        o_rsp.out_payload, want.out_payload));
            end
        end
    end

    // Drop the start line and hold until every result is in
    task automatic wait_drained();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (rsp_queue.size() != 0) @(negedge i_clk);
    endtask

    // Empty store, extremes, fill to full, overflow, stable order
    task automatic test_directed();
        send_request(kmq_pkg::OP_DEQ, 8'h00, 8'hFF, 32'hFFFF_FFFF);
        send_request(kmq_pkg::OP_ENQ, 8'hFF, 8'hFF, 32'h7FFF_FFFF);
        send_request(kmq_pkg::OP_ENQ, 8'h00, 8'h00, 32'h8000_0000);
        send_request(kmq_pkg::OP_ENQ, 8'h80, 8'h01, 32'h0000_0001);
        send_request(kmq_pkg::OP_ENQ, 8'h80, 8'h02, 32'hFFFF_FFFF);
        send_request(kmq_pkg::OP_DEQ, 8'h7F, 8'h00, 32'h0);
        send_request(kmq_pkg::OP_DEQ, 8'h80, 8'h00, 32'h0);
        send_request(kmq_pkg::OP_DEQ, 8'hFF, 8'h00, 32'h0);
        for (int i = 0; i < DEPTH - 1; i++)
            send_request(kmq_pkg::OP_ENQ, 8'(i * 17), 8'(i), $urandom());
        send_request(kmq_pkg::OP_ENQ, 8'h55, 8'hAA, 32'h1234_5678);
        send_request(kmq_pkg::OP_ENQ, 8'h00, 8'h00, 32'h0);
    endtask

    // Random traffic over a small key set so dequeues mostly hit
    task automatic test_random(input int n);
        logic [7:0]    key;
        kmq_pkg::t_op  op;
        for (int i = 0; i < n; i++) begin
            op = ($urandom_range(0, 99) < 50 + (mb_count < 4 ? 20 : 0)
                  - (mb_count > 12 ? 20 : 0)) ? kmq_pkg::OP_ENQ : kmq_pkg::OP_DEQ;
            key = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(0, 7) * 36);
            send_request(op, key, 8'($urandom()), $urandom());
        end
    endtask

    // Wait until every result is in, pause, then drain the store and miss once on it empty
    task automatic test_drain();
        wait_drained();
        repeat (40) @(negedge i_clk);
        while (mb_count > 0) send_request(kmq_pkg::OP_DEQ, mb_rcv[0], 8'h00, 32'h0);
        send_request(kmq_pkg::OP_DEQ, 8'h24, 8'h00, 32'h0);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);
        test_directed();
        test_random(800);
        test_drain();
        test_random(800);
        test_drain();
        wait_drained();
        repeat (40) @(negedge i_clk);
        if (err_count == 0 && rsp_queue.size() == 0)
            $display("keyed_mailbox_queue_core_tb: done, clean");
        else
            $display("keyed_mailbox_queue_core_tb: done, errors");
        $finish;
    end

    // Timeout guard
    initial begin
        #4000000;
        $display("keyed_mailbox_queue_core_tb: done, errors");
        $finish;
    end
endmodule
